/* rtl/core/hat_pkg.sv */
// Package for the heap allocation tracker: table sizing, command and status codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package hat_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 64;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 4;

  localparam logic [CMD_W-1:0] CMD_CALL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN = 2'd3;

  localparam logic [STAT_W-1:0] ST_CALL    = 4'd0;
  localparam logic [STAT_W-1:0] ST_NULL    = 4'd1;
  localparam logic [STAT_W-1:0] ST_REUSE   = 4'd2;
  localparam logic [STAT_W-1:0] ST_REACT   = 4'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED = 4'd4;
  localparam logic [STAT_W-1:0] ST_FREED   = 4'd5;
  localparam logic [STAT_W-1:0] ST_DOUBLE  = 4'd6;
  localparam logic [STAT_W-1:0] ST_UNALLOC = 4'd7;
  localparam logic [STAT_W-1:0] ST_LEAK    = 4'd8;
  localparam logic [STAT_W-1:0] ST_DONE    = 4'd9;
  localparam logic [STAT_W-1:0] ST_FULL    = 4'd10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SEND
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic leak_emit;
    logic done_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_scan;
    logic scan_last;
    logic found;
  } ctrl_sts_t;

endpackage

/* rtl/core/heap_allocation_tracker_unit.sv */
// Top level of the heap allocation tracker: controller and datapath.
// Depends on hat_pkg, hat_ctrl and hat_dpath.
//
//  channel | dir | tdata               | tuser          | tlast
//  s_*     | in  | address[63:0]       | command[1:0]   | -
//  m_*     | out | report_address[63:0]| status[3:0]    | last
//
// Call, return and free requests are accepted, then executed against a match vector
// registered at accept; execution waits while a result is stalled at the output.
// A leak scan with L live entries makes L + 1 passes: each pass walks the table
// one entry a cycle for the next smallest address.
// Reset clears the used and freed bits and the pending flag.
// A stalled result waits in the output register; a new request is still accepted.
module heap_allocation_tracker_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [hat_pkg::ADDR_W-1:0]  s_tdata,   // address
  input  logic [hat_pkg::CMD_W-1:0]   s_tuser,   // command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [hat_pkg::ADDR_W-1:0]  m_tdata,   // report_address
  output logic [hat_pkg::STAT_W-1:0]  m_tuser,   // status
  output logic                        m_tlast
);

  hat_pkg::ctrl_cmd_t cmd;
  hat_pkg::ctrl_sts_t sts;

  hat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hat_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* rtl/core/hat_ctrl.sv */
// Controller state machine of the heap allocation tracker.
// Sequences request execution and leak scan passes; depends on hat_pkg.
module hat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  hat_pkg::ctrl_sts_t sts,
  output hat_pkg::ctrl_cmd_t cmd
);

  hat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hat_pkg::S_IDLE: begin
        if (s_tvalid) state_next = hat_pkg::S_EXEC;
      end
      hat_pkg::S_EXEC: begin
        if (sts.is_scan) state_next = hat_pkg::S_SCAN;
        else if (sts.out_free) state_next = hat_pkg::S_IDLE;
      end
      hat_pkg::S_SCAN: begin
        if (sts.scan_last) state_next = hat_pkg::S_SEND;
      end
      hat_pkg::S_SEND: begin
        if (sts.out_free) state_next = sts.found ? hat_pkg::S_SCAN : hat_pkg::S_IDLE;
      end
      default: state_next = hat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      hat_pkg::S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      hat_pkg::S_EXEC: begin
        cmd.scan_init = sts.is_scan;
        cmd.exec      = !sts.is_scan && sts.out_free;
      end
      hat_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      hat_pkg::S_SEND: begin
        cmd.leak_emit = sts.out_free && sts.found;
        cmd.done_emit = sts.out_free && !sts.found;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/hat_dpath.sv */
// Datapath of the heap allocation tracker: address table, parallel match,
// serial leak scan and output register; depends on hat_pkg.
module hat_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hat_pkg::ADDR_W-1:0]  s_tdata,
  input  logic [hat_pkg::CMD_W-1:0]   s_tuser,
  input  hat_pkg::ctrl_cmd_t          cmd,
  output hat_pkg::ctrl_sts_t          sts,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [hat_pkg::ADDR_W-1:0]  m_tdata,
  output logic [hat_pkg::STAT_W-1:0]  m_tuser,
  output logic                        m_tlast
);

  logic [hat_pkg::ADDR_W-1:0]      entry_addr [hat_pkg::TABLE_DEPTH];
  logic [hat_pkg::TABLE_DEPTH-1:0] entry_freed;
  logic [hat_pkg::TABLE_DEPTH-1:0] entry_used;
  logic                            call_pending;

  logic [hat_pkg::CMD_W-1:0]       req_cmd;
  logic [hat_pkg::ADDR_W-1:0]      req_addr;
  logic                            req_null;
  logic [hat_pkg::TABLE_DEPTH-1:0] hit_vec;
  logic [hat_pkg::TABLE_DEPTH-1:0] hit_cmp;

  logic [hat_pkg::IDX_W-1:0]       scan_idx;
  logic                            found;
  logic                            have_prev;
  logic [hat_pkg::ADDR_W-1:0]      best;
  logic [hat_pkg::ADDR_W-1:0]      prev;

  logic                            out_valid;
  logic [hat_pkg::STAT_W-1:0]      out_status;
  logic [hat_pkg::ADDR_W-1:0]      out_addr;
  logic                            out_last;

  logic                            hit_any;
  logic [hat_pkg::IDX_W-1:0]       hit_idx;
  logic                            free_any;
  logic [hat_pkg::IDX_W-1:0]       free_idx;
  logic                            scan_last;
  logic [hat_pkg::ADDR_W-1:0]      sel_addr;
  logic                            sel_live;
  logic                            take;

  logic                            emit_valid;
  logic [hat_pkg::STAT_W-1:0]      emit_status;
  logic [hat_pkg::ADDR_W-1:0]      emit_addr;
  logic                            emit_last;
  logic                            set_pend;
  logic                            clr_pend;
  logic                            do_insert;
  logic                            set_freed;
  logic                            clr_freed;

  always_comb begin
    for (int i = 0; i < hat_pkg::TABLE_DEPTH; i++) begin
      hit_cmp[i] = entry_used[i] && (entry_addr[i] == s_tdata);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = hat_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = hat_pkg::IDX_W'(i);
      if (!entry_used[i]) free_idx = hat_pkg::IDX_W'(i);
    end
  end

  assign hit_any   = |hit_vec;
  assign free_any  = ~&entry_used;
  assign scan_last = (scan_idx == hat_pkg::IDX_W'(hat_pkg::TABLE_DEPTH - 1));
  assign sel_addr  = entry_addr[scan_idx];
  assign sel_live  = entry_used[scan_idx] && !entry_freed[scan_idx];
  assign take      = sel_live && (!have_prev || (sel_addr > prev)) &&
                     (!found || (sel_addr < best));

  always_comb begin
    emit_status = hat_pkg::ST_DONE;
    emit_addr   = req_addr;
    emit_last   = 1'b1;
    set_pend    = 1'b0;
    clr_pend    = 1'b0;
    do_insert   = 1'b0;
    set_freed   = 1'b0;
    clr_freed   = 1'b0;
    if (cmd.exec) begin
      case (req_cmd)
        hat_pkg::CMD_CALL: begin
          set_pend    = 1'b1;
          emit_status = hat_pkg::ST_CALL;
          emit_addr   = '0;
        end
        hat_pkg::CMD_RET: begin
          if (req_null) begin
            emit_status = hat_pkg::ST_NULL;
            emit_addr   = '0;
          end else if (hit_any) begin
            if (entry_freed[hit_idx]) begin
              clr_freed   = 1'b1;
              emit_status = hat_pkg::ST_REACT;
            end else begin
              emit_status = hat_pkg::ST_REUSE;
            end
          end else if (!call_pending) begin
            emit_status = hat_pkg::ST_IGNORED;
          end else begin
            clr_pend = 1'b1;
            if (free_any) begin
              do_insert   = 1'b1;
              emit_status = hat_pkg::ST_CALL;
            end else begin
              emit_status = hat_pkg::ST_FULL;
            end
          end
        end
        hat_pkg::CMD_FREE: begin
          if (!hit_any) begin
            emit_status = hat_pkg::ST_UNALLOC;
          end else if (entry_freed[hit_idx]) begin
            emit_status = hat_pkg::ST_DOUBLE;
          end else begin
            set_freed   = 1'b1;
            emit_status = hat_pkg::ST_FREED;
          end
        end
        default: begin
          emit_status = hat_pkg::ST_DONE;
          emit_addr   = '0;
        end
      endcase
    end else if (cmd.leak_emit) begin
      emit_status = hat_pkg::ST_LEAK;
      emit_addr   = best;
      emit_last   = 1'b0;
    end else begin
      emit_status = hat_pkg::ST_DONE;
      emit_addr   = '0;
    end
  end

  assign emit_valid = cmd.exec || cmd.leak_emit || cmd.done_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_freed  <= '0;
      entry_used   <= '0;
      call_pending <= 1'b0;
      hit_vec      <= '0;
      scan_idx     <= '0;
      found        <= 1'b0;
      have_prev    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.accept) hit_vec <= hit_cmp;
      if (set_pend) call_pending <= 1'b1;
      else if (clr_pend) call_pending <= 1'b0;
      if (do_insert) begin
        entry_used[free_idx]  <= 1'b1;
        entry_freed[free_idx] <= 1'b0;
      end
      if (set_freed) entry_freed[hit_idx] <= 1'b1;
      if (clr_freed) entry_freed[hit_idx] <= 1'b0;
      if (cmd.scan_init) begin
        scan_idx  <= '0;
        found     <= 1'b0;
        have_prev <= 1'b0;
      end else if (cmd.scan_step) begin
        if (take) found <= 1'b1;
        scan_idx <= scan_last ? '0 : scan_idx + hat_pkg::IDX_W'(1);
      end else if (cmd.leak_emit) begin
        scan_idx  <= '0;
        found     <= 1'b0;
        have_prev <= 1'b1;
      end
      if (emit_valid) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_cmd  <= s_tuser;
      req_addr <= s_tdata;
      req_null <= (s_tdata == '0);
    end
    if (do_insert) entry_addr[free_idx] <= req_addr;
    if (cmd.scan_step && take) best <= sel_addr;
    if (cmd.leak_emit) prev <= best;
    if (emit_valid) begin
      out_status <= emit_status;
      out_addr   <= emit_addr;
      out_last   <= emit_last;
    end
  end

  assign sts.out_free  = !out_valid || m_tready;
  assign sts.is_scan   = (req_cmd == hat_pkg::CMD_SCAN);
  assign sts.scan_last = scan_last;
  assign sts.found     = found;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_addr;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_vec))
    else $error("more than one table entry matched");
  a_freed_used: assert property (@(posedge clk) disable iff (rst)
    (entry_freed & ~entry_used) == '0)
    else $error("freed mark on an unused entry");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_valid |-> (!out_valid || m_tready))
    else $error("result emitted over a pending result");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == hat_pkg::ST_DONE) |-> (out_last && out_addr == '0))
    else $error("scan done marker malformed");
`endif

endmodule
